// ----- rtl/core/wbm_pkg.sv -----
// ----------------------------------------------------------------------------
// wbm_pkg
// shared types, codes and constants of the weighted byte mixer
// ----------------------------------------------------------------------------
package wbm_pkg;

  localparam int unsigned WeightFracBitsDef = 15;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned FactorW = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WeightW = 16;
  localparam int unsigned SumW    = 32;

  // shared multiplier operand and accumulator widths
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 17;
  localparam int unsigned AccW  = 64;

  // mix modes
  localparam logic [ModeW-1:0] MODE_TRANSFER = 3'd0;
  localparam logic [ModeW-1:0] MODE_ABOVE    = 3'd1;
  localparam logic [ModeW-1:0] MODE_BELOW    = 3'd2;
  localparam logic [ModeW-1:0] MODE_AVERAGE  = 3'd3;
  localparam logic [ModeW-1:0] MODE_ADD      = 3'd4;
  localparam logic [ModeW-1:0] MODE_SUB      = 3'd5;
  localparam logic [ModeW-1:0] MODE_MUL      = 3'd6;

  // register indexes
  localparam logic REG_MIX_MODE   = 1'b0;
  localparam logic REG_MIX_FACTOR = 1'b1;

  localparam logic [FactorW-1:0] FactorOne = 16'd32768;

  // coefficients of the shared unit
  localparam logic signed [MulBW-1:0] CoefFull    = 17'sd510;
  localparam logic signed [MulBW-1:0] CoefHalf    = 17'sd255;
  localparam logic signed [MulBW-1:0] CoefNegFull = -17'sd510;
  localparam logic signed [MulBW-1:0] CoefNegHalf = -17'sd255;
  localparam logic signed [MulBW-1:0] CoefZero    = 17'sd0;

  // product shift selection of the shared unit
  localparam logic [1:0] SH_NONE  = 2'd0;
  localparam logic [1:0] SH_FRAC  = 2'd1;
  localparam logic [1:0] SH_WORD  = 2'd2;
  localparam logic [1:0] SH_SCALE = 2'd3;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic [1:0] sh;
  } mac_ctrl_t;

endpackage

// ----- rtl/core/wbm_mac.sv -----
// ----------------------------------------------------------------------------
// wbm_mac
// shared signed multiply-accumulate unit with a selectable product shift
// ----------------------------------------------------------------------------
module wbm_mac #(
  parameter int unsigned WeightFracBits = wbm_pkg::WeightFracBitsDef
) (
  input  logic                                clk_i,
  input  wbm_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [wbm_pkg::MulAW-1:0]    a_i,
  input  logic signed [wbm_pkg::MulBW-1:0]    b_i,
  output logic signed [wbm_pkg::AccW-1:0]     acc_o
);

  localparam int unsigned ProdW = wbm_pkg::MulAW + wbm_pkg::MulBW;

  logic signed [ProdW-1:0]         prod;
  logic signed [wbm_pkg::AccW-1:0] prod_ext;
  logic signed [wbm_pkg::AccW-1:0] prod_sh;
  logic signed [wbm_pkg::AccW-1:0] acc_d, acc_q;

  assign prod     = a_i * b_i;
  assign prod_ext = wbm_pkg::AccW'(prod);

  always_comb begin
    case (ctrl_i.sh)
      wbm_pkg::SH_FRAC:  prod_sh = prod_ext <<< WeightFracBits;
      wbm_pkg::SH_WORD:  prod_sh = prod_ext <<< 32;
      wbm_pkg::SH_SCALE: prod_sh = prod_ext <<< (WeightFracBits + 15);
      default:           prod_sh = prod_ext;
    endcase
    acc_d = (ctrl_i.clr ? '0 : acc_q) + prod_sh;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/core/wbm_fin.sv -----
// ----------------------------------------------------------------------------
// wbm_fin
// final stage: threshold test, clamp to [0,1] and scaling to a byte
// ----------------------------------------------------------------------------
module wbm_fin #(
  parameter int unsigned WeightFracBits = wbm_pkg::WeightFracBitsDef
) (
  input  logic [wbm_pkg::ModeW-1:0]       mode_i,
  input  logic [wbm_pkg::FactorW-1:0]     factor_i,
  input  logic [wbm_pkg::ByteW-1:0]       dst_i,
  input  logic [wbm_pkg::SumW-1:0]        sum_i,
  input  logic signed [wbm_pkg::AccW-1:0] mix_i,
  output logic [wbm_pkg::ByteW-1:0]       result_o,
  output logic                            untouched_o
);

  // full scale of the mix numerator: 2 * 255 * 255 * 2^(frac + 15)
  localparam logic signed [wbm_pkg::AccW-1:0] MixDen =
    wbm_pkg::AccW'(130050) <<< (WeightFracBits + 15);

  logic [23:0] thr_lhs, thr_rhs;
  logic        keep, thr_mode;
  logic [7:0]  repl_val, mix_val;
  logic [15:0] quo_num;
  logic [15:0] quo_sum;

  always_comb begin
    thr_lhs  = {1'b0, dst_i, 15'd0};
    thr_rhs  = {factor_i, 8'd0} - 24'(factor_i);
    thr_mode = (mode_i == wbm_pkg::MODE_ABOVE) || (mode_i == wbm_pkg::MODE_BELOW);
    keep     = ((mode_i == wbm_pkg::MODE_ABOVE) && (thr_lhs < thr_rhs)) ||
               ((mode_i == wbm_pkg::MODE_BELOW) && (thr_lhs > thr_rhs));

    // replace without blending: sum over 2^frac, saturated
    if (|sum_i[wbm_pkg::SumW-1:WeightFracBits+8]) begin
      repl_val = 8'hff;
    end else begin
      repl_val = sum_i[WeightFracBits+7:WeightFracBits];
    end

    // floor(u / 255) for u below 255*255
    quo_num = mix_i[WeightFracBits+31:WeightFracBits+16];
    quo_sum = quo_num + 16'd1 + 16'(quo_num[15:8]);
    if (mix_i <= 0) begin
      mix_val = 8'd0;
    end else if (mix_i >= MixDen) begin
      mix_val = 8'hff;
    end else begin
      mix_val = quo_sum[15:8];
    end

    if (keep) begin
      result_o    = dst_i;
      untouched_o = 1'b1;
    end else if (thr_mode) begin
      result_o    = repl_val;
      untouched_o = 1'b0;
    end else begin
      result_o    = mix_val;
      untouched_o = 1'b0;
    end
  end

endmodule

// ----- rtl/core/weighted_byte_mix.sv -----
// ----------------------------------------------------------------------------
// weighted_byte_mix
// weighted sum of a run of source bytes, blended into a destination byte
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | word
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata src,weight,dst; tlast
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata result; tuser untouched
//  cfg      | in        | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
//  every word goes through a product, then a saturating add; a last word then
//  runs C0, C1, T0, T1, T2, FIN in blend modes, straight to FIN in threshold
//  modes, all products going through one 33x17 multiply-accumulate unit
//  the result sits in an output register; s_axis takes more words meanwhile
//  the final cycle waits while a previous result is still not taken
//  reset is asynchronous active low and leaves mode transfer, factor 1.0
// ----------------------------------------------------------------------------
module weighted_byte_mix #(
  parameter int unsigned WeightFracBits = wbm_pkg::WeightFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // src_value[7:0], weight[23:8], dst_value[31:24]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // result_value[7:0]
  output logic        m_axis_tuser,   // untouched[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ACC  = 4'd1;
  localparam logic [3:0] ST_C0   = 4'd2;
  localparam logic [3:0] ST_C1   = 4'd3;
  localparam logic [3:0] ST_T0   = 4'd4;
  localparam logic [3:0] ST_T1   = 4'd5;
  localparam logic [3:0] ST_T2   = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;

  logic [3:0] state_d, state_q;

  logic [wbm_pkg::ModeW-1:0]   mode_q;
  logic [wbm_pkg::FactorW-1:0] factor_q;
  logic [wbm_pkg::SumW-1:0]    ws_d, ws_q;
  logic [wbm_pkg::SumW-1:0]    sum_q;
  logic [wbm_pkg::ByteW-1:0]   dst_q;
  logic                        last_q;
  logic [31:0]                 chi_q;

  logic                        out_valid_q;
  logic [wbm_pkg::ByteW-1:0]   out_data_q;
  logic                        out_user_q;

  wbm_pkg::mac_ctrl_t                  mac_ctrl;
  logic signed [wbm_pkg::MulAW-1:0]    mac_a;
  logic signed [wbm_pkg::MulBW-1:0]    mac_b;
  logic signed [wbm_pkg::AccW-1:0]     acc;

  logic signed [wbm_pkg::MulBW-1:0]    coef_src, coef_dst;
  logic [wbm_pkg::SumW:0]              ws_sum;
  logic [wbm_pkg::ByteW-1:0]           fin_result;
  logic                                fin_untouched;
  logic                                in_acc, out_load, thr_mode;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign thr_mode      = (mode_q == wbm_pkg::MODE_ABOVE) || (mode_q == wbm_pkg::MODE_BELOW);

  // coefficients: C = k_src*sum + k_dst*dst*2^frac, then t = f*C + 2^15*510*dst*2^frac
  always_comb begin
    case (mode_q)
      wbm_pkg::MODE_AVERAGE: begin
        coef_src = wbm_pkg::CoefHalf;
        coef_dst = wbm_pkg::CoefNegHalf;
      end
      wbm_pkg::MODE_ADD: begin
        coef_src = wbm_pkg::CoefFull;
        coef_dst = wbm_pkg::CoefZero;
      end
      wbm_pkg::MODE_SUB: begin
        coef_src = wbm_pkg::CoefNegFull;
        coef_dst = wbm_pkg::CoefZero;
      end
      wbm_pkg::MODE_MUL: begin
        coef_src = {8'd0, dst_q, 1'b0};
        coef_dst = wbm_pkg::CoefNegFull;
      end
      default: begin
        coef_src = wbm_pkg::CoefFull;
        coef_dst = wbm_pkg::CoefNegFull;
      end
    endcase
  end

  assign ws_sum = {1'b0, ws_q} + 33'(acc[23:0]);

  always_comb begin
    state_d      = state_q;
    ws_d         = ws_q;
    mac_ctrl     = '{en: 1'b0, clr: 1'b0, sh: wbm_pkg::SH_NONE};
    mac_a        = {25'd0, s_axis_tdata[7:0]};
    mac_b        = {1'b0, s_axis_tdata[23:8]};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mac_ctrl = '{en: 1'b1, clr: 1'b1, sh: wbm_pkg::SH_NONE};
          state_d  = ST_ACC;
        end
      end
      ST_ACC: begin
        // saturating accumulate of src * weight
        ws_d = ws_sum[wbm_pkg::SumW] ? '1 : ws_sum[wbm_pkg::SumW-1:0];
        if (last_q) begin
          state_d = thr_mode ? ST_FIN : ST_C0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_C0: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1, sh: wbm_pkg::SH_NONE};
        mac_a    = {1'b0, sum_q};
        mac_b    = coef_src;
        state_d  = ST_C1;
      end
      ST_C1: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, sh: wbm_pkg::SH_FRAC};
        mac_a    = {25'd0, dst_q};
        mac_b    = coef_dst;
        state_d  = ST_T0;
      end
      ST_T0: begin
        // low word of C times factor
        mac_ctrl = '{en: 1'b1, clr: 1'b1, sh: wbm_pkg::SH_NONE};
        mac_a    = {1'b0, acc[31:0]};
        mac_b    = {1'b0, factor_q};
        state_d  = ST_T1;
      end
      ST_T1: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, sh: wbm_pkg::SH_WORD};
        mac_a    = {chi_q[31], chi_q};
        mac_b    = {1'b0, factor_q};
        state_d  = ST_T2;
      end
      ST_T2: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, sh: wbm_pkg::SH_SCALE};
        mac_a    = {25'd0, dst_q};
        mac_b    = wbm_pkg::CoefFull;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= '0;
      mode_q      <= wbm_pkg::MODE_TRANSFER;
      factor_q    <= wbm_pkg::FactorOne;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_ACC) && last_q) begin
        ws_q <= '0;
      end else begin
        ws_q <= ws_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          wbm_pkg::REG_MIX_MODE:   mode_q   <= cfg_data_i[wbm_pkg::ModeW-1:0];
          wbm_pkg::REG_MIX_FACTOR: factor_q <= cfg_data_i;
          default:                 mode_q   <= mode_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dst_q  <= s_axis_tdata[31:24];
      last_q <= s_axis_tlast;
    end
    if ((state_q == ST_ACC) && last_q) begin
      sum_q <= ws_d;
    end
    if (state_q == ST_T0) begin
      chi_q <= acc[63:32];
    end
    if (out_load) begin
      out_data_q <= fin_result;
      out_user_q <= fin_untouched;
    end
  end

  wbm_mac #(
    .WeightFracBits(WeightFracBits)
  ) u_mac (
    .clk_i (clk_i),
    .ctrl_i(mac_ctrl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  wbm_fin #(
    .WeightFracBits(WeightFracBits)
  ) u_fin (
    .mode_i     (mode_q),
    .factor_i   (factor_q),
    .dst_i      (dst_q),
    .sum_i      (sum_q),
    .mix_i      (acc),
    .result_o   (fin_result),
    .untouched_o(fin_untouched)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/core/wbm_checker.sv -----
// ----------------------------------------------------------------------------
// wbm_checker
// port level checks of the weighted byte mixer, bound to the top level
// ----------------------------------------------------------------------------
module wbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its word
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one word at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again without accumulate cycle");

  // a word without tlast never raises a result next cycle
  a_no_result_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("result from a word without tlast");

  // a new result only appears while the input side is busy
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised while idle");

endmodule

bind weighted_byte_mix wbm_checker u_wbm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
